// ----- hw/rtl/b2da_pkg.sv -----
// shared constants and types for the binary to decimal ascii converter
`default_nettype none

package b2da_pkg;

	localparam int InWidth   = 32;
	localparam int MaxDigits = 10;
	localparam int DigitW    = 4;
	localparam int IdxW      = $clog2(MaxDigits);
	localparam int CntW      = $clog2(InWidth);
	localparam int CharW     = 6;
	localparam int QDepth    = 2;
	localparam int QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;
	localparam int QCntW     = $clog2(QDepth + 1);

	localparam logic [CharW-1:0] AsciiZero = CharW'(48);

	typedef logic [MaxDigits-1:0][DigitW-1:0] bcd_t;

	// one converted value: packed bcd digits and the index of the leading digit
	typedef struct packed {
		bcd_t            digits;
		logic [IdxW-1:0] top;
	} q_entry_t;

endpackage

`default_nettype wire

// ----- hw/rtl/b2da_front.sv -----
// front end: accepts a value and converts it to bcd by shift and add-3
`default_nettype none

module b2da_front
	import b2da_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [InWidth-1:0] value,
	output logic                    push,
	output q_entry_t                push_data,
	input  wire logic               full
);

	typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_PUSH} state_t;

	state_t             state_q;
	logic [CntW-1:0]    cnt_q;
	logic [InWidth-1:0] bin_q;
	bcd_t               bcd_q;
	bcd_t               adj;
	logic [IdxW-1:0]    top;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < MaxDigits; i++) begin
			adj[i] = (bcd_q[i] >= DigitW'(5)) ? bcd_q[i] + DigitW'(3) : bcd_q[i];
		end
	end

	// leading nonzero digit, zero keeps a single digit
	always_comb begin
		top = '0;
		for (int i = 0; i < MaxDigits; i++) begin
			if (bcd_q[i] != '0) top = IdxW'(i);
		end
	end

	assign in_ready         = (state_q == ST_IDLE);
	assign push             = (state_q == ST_PUSH) && !full;
	assign push_data.digits = bcd_q;
	assign push_data.top    = top;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_CONV;
						cnt_q   <= '0;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + CntW'(1);
					if (cnt_q == CntW'(InWidth - 1)) state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!full) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (state_q == ST_CONV) begin
			{bcd_q, bin_q} <= {adj, bin_q} << 1;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/b2da_fifo.sv -----
// short queue of converted values between front and back end
`default_nettype none

module b2da_fifo
	import b2da_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire q_entry_t push_data,
	output logic          full,
	input  wire logic     pop,
	output q_entry_t      pop_data,
	output logic          empty
);

	q_entry_t         mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] cnt_q;

	assign full     = (cnt_q == QCntW'(QDepth));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
			end
			if (push && !pop) cnt_q <= cnt_q + QCntW'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue read while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCntW'(QDepth))
		else $error("queue fill count out of range");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/b2da_back.sv -----
// back end: sends the digits of one queued value, most significant first
`default_nettype none

module b2da_back
	import b2da_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      empty,
	input  wire q_entry_t  pop_data,
	output logic           pop,
	output logic           out_valid,
	input  wire logic      out_ready,
	output logic [CharW-1:0] digit_char,
	output logic           last
);

	logic            busy_q;
	bcd_t            bcd_q;
	logic [IdxW-1:0] idx_q;

	assign pop        = !busy_q && !empty;
	assign out_valid  = busy_q;
	assign digit_char = AsciiZero + CharW'(bcd_q[idx_q]);
	assign last       = (idx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= pop_data.top;
		end else if (busy_q && out_ready) begin
			if (idx_q == '0) busy_q <= 1'b0;
			else idx_q <= idx_q - IdxW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) bcd_q <= pop_data.digits;
	end

`ifndef SYNTHESIS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < IdxW'(MaxDigits)))
		else $error("digit index beyond buffer");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/binary_to_decimal_ascii_top.sv -----
// top level of the 32-bit binary to decimal ascii converter
//
// input channel: in_valid/in_ready with a 32-bit unsigned value per beat.
// output channel: out_valid/out_ready with one ascii digit per beat,
// most significant first, no leading zeros, last set on the final digit.
// zero gives the single digit '0'; a value gives 1 to 10 beats.
// the front end converts by shift and add-3, then writes the bcd digits
// into a two-entry queue; it takes no new value until the last one has
// been written into the queue.
// the back end sends one digit per cycle while out_ready is high, and
// pops the next value only after the last digit of the one before; the
// first digit follows the conversion, the queue and the back end register.
// when the receiver stalls, the back end holds its digit and the queue
// fills; the front end then holds in_ready low after its next conversion.
// reset empties the queue and returns both ends to idle at once.
`default_nettype none

module binary_to_decimal_ascii_top
	import b2da_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [InWidth-1:0] value,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [CharW-1:0]        digit_char,
	output logic                    last
);

	logic     push;
	logic     full;
	logic     pop;
	logic     empty;
	q_entry_t push_data;
	q_entry_t pop_data;

	b2da_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	b2da_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	b2da_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (empty),
		.pop_data   (pop_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_char (digit_char),
		.last       (last)
	);

endmodule

`default_nettype wire
